/* rtl/color_tag_bounding_box_tracker_assert.svh */
// assertion macros for the color tag bounding box tracker
// used by the port checker; no other dependencies
`ifndef COLOR_TAG_BOUNDING_BOX_TRACKER_ASSERT_SVH
`define COLOR_TAG_BOUNDING_BOX_TRACKER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CTBT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define CTBT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ctbt_pkg.sv */
// shared types and constants of the color tag bounding box tracker
// no dependencies
package ctbt_pkg;

    localparam int COORD_W     = 12;
    localparam int SLOT_MAX_W  = 17;
    localparam int EPOCH_W     = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef logic [SLOT_MAX_W-1:0] slot_t;
    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [EPOCH_W-1:0]    epoch_t;

    // epoch zero marks a swept entry and is never live
    localparam epoch_t EPOCH_NONE  = '0;
    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_LAST  = '1;

    // color codes
    localparam logic [7:0] RED_CHECK  = 8'd200;
    localparam logic [7:0] RED_TAG    = 8'd201;
    localparam logic [7:0] GREEN_MARK = 8'd100;
    localparam logic [7:0] CHAN_FULL  = 8'd255;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CHECK = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_MARK  = 2'd2,
        KIND_NAME  = 2'd3
    } rkind_t;

    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,
        CLS_CHECK = 3'd1,
        CLS_DIGIT = 3'd2,
        CLS_MARK  = 3'd3,
        CLS_NAME  = 3'd4
    } cls_t;

    // work for the back end
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_WIDEN = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic {
        BK_SWEEP = 1'b0,
        BK_RUN   = 1'b1
    } bk_state_t;

    typedef struct packed {
        op_t    op;
        slot_t  slot;
        coord_t x;
        coord_t y;
        cls_t   cls;
        logic   dropped;
    } item_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } back_ctl_t;

endpackage

/* rtl/color_tag_bounding_box_tracker.sv */
// top level of the color tag bounding box tracker
// depends on ctbt_pkg, ctbt_front, ctbt_queue and ctbt_back
//
//   channel  direction  tdata                                   tuser
//   s_       in         red green blue column row read_kind     command
//                       read_major read_minor (62 bits in 64)
//   m_       out        pixel_class dropped box_found box_xmin  -
//                       box_xmax box_ymin box_ymax (53 in 56)
//
// one word per clock while m_tready is high and no clearing pass runs; a word goes
// through the queue and the stage to the output register; the box memory has one read
// and one write port, and a same-box pixel that follows directly is served by a bypass
// of the previous write; after reset, and after every seventh clear, a clearing pass
// walks the box memory one entry a cycle, 1194 entries by default, with s_tready low
// a four-word queue lets the input keep flowing, until full, while m_tready is low
module color_tag_bounding_box_tracker #(
    parameter int QUESTION_COUNT = 64,
    parameter int ANSWER_COUNT   = 16,
    parameter int ID_ROWS        = 4,
    parameter int ID_DIGITS      = 41,
    parameter int MARK_COUNT     = 5,
    parameter int COORD_BITS     = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // red, green, blue, column, row, read_kind,
                                   // read_major, read_minor, zero pad
    input  logic [1:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // pixel_class, dropped, box_found, box_xmin,
                                   // box_xmax, box_ymin, box_ymax, zero pad
);

    ctbt_pkg::item_t     front_item;
    ctbt_pkg::item_t     head;
    ctbt_pkg::back_ctl_t back_ctl;
    logic                q_full;
    logic                q_empty;
    logic                push;

    // accept while the queue has room and no clearing pass runs
    assign s_tready = !q_full && !back_ctl.busy;
    assign push     = s_tvalid && s_tready;

    ctbt_front #(
        .QUESTION_COUNT (QUESTION_COUNT),
        .ANSWER_COUNT   (ANSWER_COUNT),
        .ID_ROWS        (ID_ROWS),
        .ID_DIGITS      (ID_DIGITS),
        .MARK_COUNT     (MARK_COUNT),
        .COORD_BITS     (COORD_BITS)
    ) u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    ctbt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (back_ctl.pop),
        .empty     (q_empty),
        .head      (head)
    );

    ctbt_back #(
        .QUESTION_COUNT (QUESTION_COUNT),
        .ANSWER_COUNT   (ANSWER_COUNT),
        .ID_ROWS        (ID_ROWS),
        .ID_DIGITS      (ID_DIGITS),
        .MARK_COUNT     (MARK_COUNT),
        .COORD_BITS     (COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_empty),
        .head       (head),
        .ctl        (back_ctl),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* rtl/ctbt_front.sv */
// front end: unpacks an input word, classifies the pixel and forms the box slot
// depends on ctbt_pkg
module ctbt_front #(
    parameter int QUESTION_COUNT = 64,
    parameter int ANSWER_COUNT   = 16,
    parameter int ID_ROWS        = 4,
    parameter int ID_DIGITS      = 41,
    parameter int MARK_COUNT     = 5,
    parameter int COORD_BITS     = 12
) (
    input  logic [63:0]         s_tdata,  // red, green, blue, column, row, read_kind,
                                          // read_major, read_minor, zero pad
    input  logic [1:0]          s_tuser,  // command
    output ctbt_pkg::item_t     item
);

    localparam int ID_BASE   = QUESTION_COUNT * ANSWER_COUNT;
    localparam int MARK_BASE = ID_BASE + ID_ROWS * ID_DIGITS;
    localparam int NAME_SLOT = MARK_BASE + MARK_COUNT;
    localparam ctbt_pkg::coord_t COORD_MASK = ctbt_pkg::coord_t'((1 << COORD_BITS) - 1);

    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    ctbt_pkg::coord_t  column;
    ctbt_pkg::coord_t  row;
    logic [1:0]        read_kind;
    logic [5:0]        read_major;
    logic [5:0]        read_minor;
    logic              gray;
    logic              check_ok;
    logic              digit_ok;
    logic              mark_ok;
    logic              rd_check_ok;
    logic              rd_digit_ok;
    logic              rd_mark_ok;
    ctbt_pkg::slot_t   check_slot;
    ctbt_pkg::slot_t   digit_slot;
    ctbt_pkg::slot_t   mark_slot;
    ctbt_pkg::slot_t   rd_check_slot;
    ctbt_pkg::slot_t   rd_digit_slot;
    ctbt_pkg::slot_t   rd_mark_slot;

    // field unpacking
    assign red        = s_tdata[7:0];
    assign green      = s_tdata[15:8];
    assign blue       = s_tdata[23:16];
    assign column     = s_tdata[35:24];
    assign row        = s_tdata[47:36];
    assign read_kind  = s_tdata[49:48];
    assign read_major = s_tdata[55:50];
    assign read_minor = s_tdata[61:56];

    // range checks and slot arithmetic for pixels
    assign gray       = (red == green) && (red == blue);
    assign check_ok   = (green < QUESTION_COUNT) && (blue < ANSWER_COUNT);
    assign digit_ok   = (green < ID_ROWS) && (blue < ID_DIGITS);
    assign mark_ok    = blue < MARK_COUNT;
    assign check_slot = ctbt_pkg::slot_t'(green) * ctbt_pkg::slot_t'(ANSWER_COUNT)
                      + ctbt_pkg::slot_t'(blue);
    assign digit_slot = ctbt_pkg::slot_t'(ID_BASE)
                      + ctbt_pkg::slot_t'(green) * ctbt_pkg::slot_t'(ID_DIGITS)
                      + ctbt_pkg::slot_t'(blue);
    assign mark_slot  = ctbt_pkg::slot_t'(MARK_BASE) + ctbt_pkg::slot_t'(blue);

    // range checks and slot arithmetic for reads
    assign rd_check_ok   = (read_major < QUESTION_COUNT) && (read_minor < ANSWER_COUNT);
    assign rd_digit_ok   = (read_major < ID_ROWS) && (read_minor < ID_DIGITS);
    assign rd_mark_ok    = read_major < MARK_COUNT;
    assign rd_check_slot = ctbt_pkg::slot_t'(read_major) * ctbt_pkg::slot_t'(ANSWER_COUNT)
                         + ctbt_pkg::slot_t'(read_minor);
    assign rd_digit_slot = ctbt_pkg::slot_t'(ID_BASE)
                         + ctbt_pkg::slot_t'(read_major) * ctbt_pkg::slot_t'(ID_DIGITS)
                         + ctbt_pkg::slot_t'(read_minor);
    assign rd_mark_slot  = ctbt_pkg::slot_t'(MARK_BASE) + ctbt_pkg::slot_t'(read_major);

    // command decode and pixel classification
    always_comb begin
        item         = '0;
        item.op      = ctbt_pkg::OP_PASS;
        item.cls     = ctbt_pkg::CLS_NONE;
        item.x       = column & COORD_MASK;
        item.y       = row & COORD_MASK;
        unique case (ctbt_pkg::cmd_t'(s_tuser))
            ctbt_pkg::CMD_PIXEL: begin
                priority if (red == ctbt_pkg::RED_CHECK && !gray) begin
                    item.cls     = ctbt_pkg::CLS_CHECK;
                    item.op      = check_ok ? ctbt_pkg::OP_WIDEN : ctbt_pkg::OP_PASS;
                    item.slot    = check_slot;
                    item.dropped = !check_ok;
                end else if (red == ctbt_pkg::RED_TAG && green == ctbt_pkg::GREEN_MARK) begin
                    item.cls     = ctbt_pkg::CLS_MARK;
                    item.op      = mark_ok ? ctbt_pkg::OP_WIDEN : ctbt_pkg::OP_PASS;
                    item.slot    = mark_slot;
                    item.dropped = !mark_ok;
                end else if (red == ctbt_pkg::RED_TAG && green == ctbt_pkg::CHAN_FULL
                             && blue == ctbt_pkg::CHAN_FULL) begin
                    item.cls     = ctbt_pkg::CLS_NAME;
                    item.op      = ctbt_pkg::OP_WIDEN;
                    item.slot    = ctbt_pkg::slot_t'(NAME_SLOT);
                end else if (red == ctbt_pkg::RED_TAG && !gray) begin
                    item.cls     = ctbt_pkg::CLS_DIGIT;
                    item.op      = digit_ok ? ctbt_pkg::OP_WIDEN : ctbt_pkg::OP_PASS;
                    item.slot    = digit_slot;
                    item.dropped = !digit_ok;
                end else begin
                    item.cls     = ctbt_pkg::CLS_NONE;
                end
            end
            ctbt_pkg::CMD_CLEAR: begin
                item.op = ctbt_pkg::OP_CLEAR;
            end
            ctbt_pkg::CMD_READ: begin
                unique case (ctbt_pkg::rkind_t'(read_kind))
                    ctbt_pkg::KIND_CHECK: begin
                        item.op   = rd_check_ok ? ctbt_pkg::OP_READ : ctbt_pkg::OP_PASS;
                        item.slot = rd_check_ok ? rd_check_slot : '0;
                    end
                    ctbt_pkg::KIND_DIGIT: begin
                        item.op   = rd_digit_ok ? ctbt_pkg::OP_READ : ctbt_pkg::OP_PASS;
                        item.slot = rd_digit_ok ? rd_digit_slot : '0;
                    end
                    ctbt_pkg::KIND_MARK: begin
                        item.op   = rd_mark_ok ? ctbt_pkg::OP_READ : ctbt_pkg::OP_PASS;
                        item.slot = rd_mark_ok ? rd_mark_slot : '0;
                    end
                    ctbt_pkg::KIND_NAME: begin
                        item.op   = ctbt_pkg::OP_READ;
                        item.slot = ctbt_pkg::slot_t'(NAME_SLOT);
                    end
                endcase
            end
            ctbt_pkg::CMD_NOP: begin
                item.op = ctbt_pkg::OP_PASS;
            end
        endcase
    end

endmodule

/* rtl/ctbt_queue.sv */
// short queue of classified words between the front and back ends
// depends on ctbt_pkg
module ctbt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ctbt_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output ctbt_pkg::item_t  head
);

    localparam logic [ctbt_pkg::QPTR_W:0] COUNT_FULL = (ctbt_pkg::QPTR_W + 1)'(ctbt_pkg::QUEUE_DEPTH);

    ctbt_pkg::item_t               q_reg [ctbt_pkg::QUEUE_DEPTH];
    logic [ctbt_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ctbt_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [ctbt_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ctbt_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [ctbt_pkg::QPTR_W:0]     count_reg;
    logic [ctbt_pkg::QPTR_W:0]     count_next;

    assign full  = count_reg == COUNT_FULL;
    assign empty = count_reg == '0;
    assign head  = q_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/ctbt_back.sv */
// back end: box memory with epoch tags, read-modify-write stage, output register
// depends on ctbt_pkg
module ctbt_back #(
    parameter int QUESTION_COUNT = 64,
    parameter int ANSWER_COUNT   = 16,
    parameter int ID_ROWS        = 4,
    parameter int ID_DIGITS      = 41,
    parameter int MARK_COUNT     = 5,
    parameter int COORD_BITS     = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  ctbt_pkg::item_t     head,
    output ctbt_pkg::back_ctl_t ctl,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata   // pixel_class, dropped, box_found, box_xmin,
                                          // box_xmax, box_ymin, box_ymax, zero pad
);

    localparam int BOX_TOTAL = QUESTION_COUNT * ANSWER_COUNT + ID_ROWS * ID_DIGITS
                             + MARK_COUNT + 1;
    localparam int SLOT_W    = $clog2(BOX_TOTAL);
    localparam int EXT_W     = (COORD_BITS < ctbt_pkg::COORD_W) ? COORD_BITS
                                                                : ctbt_pkg::COORD_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BOX_TOTAL - 1);

    typedef logic [EXT_W-1:0] ext_t;

    typedef struct packed {
        ctbt_pkg::epoch_t tag;
        ext_t             xmin;
        ext_t             xmax;
        ext_t             ymin;
        ext_t             ymax;
    } entry_t;

    entry_t               mem [BOX_TOTAL];

    ctbt_pkg::bk_state_t  state_reg;
    ctbt_pkg::bk_state_t  state_next;
    logic [SLOT_W-1:0]    sweep_addr_reg;
    logic [SLOT_W-1:0]    sweep_addr_next;
    ctbt_pkg::epoch_t     epoch_reg;
    ctbt_pkg::epoch_t     epoch_next;

    logic                 s1_valid_reg;
    ctbt_pkg::item_t      s1_item_reg;
    entry_t               rd_data_reg;
    logic                 fwd_reg;
    entry_t               fwd_data_reg;

    logic                 m_valid_reg;
    logic [55:0]          m_data_reg;
    logic [55:0]          m_data_next;

    logic                 advance;
    logic                 wrap_hold;
    logic                 pop;
    entry_t               cur;
    logic                 hit;
    ext_t                 px;
    ext_t                 py;
    entry_t               widened;
    logic                 s1_write;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    entry_t               mem_wdata;
    logic                 found;
    ctbt_pkg::coord_t     out_xmin;
    ctbt_pkg::coord_t     out_xmax;
    ctbt_pkg::coord_t     out_ymin;
    ctbt_pkg::coord_t     out_ymax;

    // flow control: the stage moves when the output register can take a word
    assign advance   = !m_valid_reg || m_tready;
    assign wrap_hold = s1_valid_reg && (s1_item_reg.op == ctbt_pkg::OP_CLEAR)
                     && (epoch_reg == ctbt_pkg::EPOCH_LAST);
    assign pop       = advance && head_valid && (state_reg == ctbt_pkg::BK_RUN) && !wrap_hold;
    assign ctl.pop   = pop;
    assign ctl.busy  = state_reg == ctbt_pkg::BK_SWEEP;

    // current box contents, with bypass of the write made as the item entered the stage
    assign cur = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign hit = cur.tag == epoch_reg;
    assign px  = s1_item_reg.x[EXT_W-1:0];
    assign py  = s1_item_reg.y[EXT_W-1:0];

    // box widening
    always_comb begin
        widened.tag = epoch_reg;
        if (!hit) begin
            widened.xmin = px;
            widened.xmax = px;
            widened.ymin = py;
            widened.ymax = py;
        end else begin
            widened.xmin = (px < cur.xmin) ? px : cur.xmin;
            widened.xmax = (px > cur.xmax) ? px : cur.xmax;
            widened.ymin = (py < cur.ymin) ? py : cur.ymin;
            widened.ymax = (py > cur.ymax) ? py : cur.ymax;
        end
    end

    assign s1_write = advance && s1_valid_reg && (s1_item_reg.op == ctbt_pkg::OP_WIDEN);

    // memory write port: sweep or widened box
    always_comb begin
        if (state_reg == ctbt_pkg::BK_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_write;
            mem_waddr = s1_item_reg.slot[SLOT_W-1:0];
            mem_wdata = widened;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop) begin
            rd_data_reg <= mem[head.slot[SLOT_W-1:0]];
        end
    end

    // sweep and epoch control
    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        epoch_next      = epoch_reg;
        unique case (state_reg)
            ctbt_pkg::BK_SWEEP: begin
                sweep_addr_next = SLOT_W'(sweep_addr_reg + 1'b1);
                if (sweep_addr_reg == LAST_SLOT) begin
                    state_next = ctbt_pkg::BK_RUN;
                    epoch_next = ctbt_pkg::EPOCH_FIRST;
                end
            end
            ctbt_pkg::BK_RUN: begin
                if (advance && s1_valid_reg && s1_item_reg.op == ctbt_pkg::OP_CLEAR) begin
                    if (epoch_reg == ctbt_pkg::EPOCH_LAST) begin
                        state_next      = ctbt_pkg::BK_SWEEP;
                        sweep_addr_next = '0;
                    end else begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ctbt_pkg::BK_SWEEP;
            sweep_addr_reg <= '0;
            epoch_reg      <= ctbt_pkg::EPOCH_FIRST;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            epoch_reg      <= epoch_next;
        end
    end

    // result formatting
    assign found    = (s1_item_reg.op == ctbt_pkg::OP_READ) && hit;
    assign out_xmin = found ? ctbt_pkg::coord_t'(cur.xmin) : '0;
    assign out_xmax = found ? ctbt_pkg::coord_t'(cur.xmax) : '0;
    assign out_ymin = found ? ctbt_pkg::coord_t'(cur.ymin) : '0;
    assign out_ymax = found ? ctbt_pkg::coord_t'(cur.ymax) : '0;
    assign m_data_next = {3'b000, out_ymax, out_ymin, out_xmax, out_xmin, found,
                          s1_item_reg.dropped, s1_item_reg.cls};

    // stage and output control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= pop;
            fwd_reg      <= pop && s1_write && (head.slot == s1_item_reg.slot);
            m_valid_reg  <= s1_valid_reg;
        end
    end

    // stage and output payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            fwd_data_reg <= widened;
            m_data_reg   <= m_data_next;
            if (pop) begin
                s1_item_reg <= head;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/ctbt_checker.sv */
// port checker for the color tag bounding box tracker, bound to the top level
// depends on color_tag_bounding_box_tracker_assert.svh
`include "color_tag_bounding_box_tracker_assert.svh"

module ctbt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    logic [2:0] out_cls;
    logic       out_dropped;
    logic       out_found;
    logic       in_seen;

    assign out_cls     = m_tdata[2:0];
    assign out_dropped = m_tdata[3];
    assign out_found   = m_tdata[4];
    assign in_seen     = s_tvalid && s_tready && (s_tdata[63:62] == 2'b00) && (s_tuser != 2'b11);

    // a stalled result word holds
    `CTBT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // only the five pixel classes appear
    `CTBT_ASSERT_NOW(a_cls_range, aclk, aresetn, m_tvalid, out_cls <= 3'd4 || !in_seen && out_cls <= 3'd4, "pixel class out of range")

    // a dropped pixel is a checkbox, id digit or mark
    `CTBT_ASSERT_NOW(a_drop_cls, aclk, aresetn, m_tvalid && out_dropped, out_cls == 3'd1 || out_cls == 3'd2 || out_cls == 3'd3, "dropped flag on a class without an index")

    // a found box comes only from a read, which carries no pixel class
    `CTBT_ASSERT_NOW(a_found_read, aclk, aresetn, m_tvalid && out_found, out_cls == 3'd0 && !out_dropped, "box found on a pixel result")

    // extents are zero unless a box was found
    `CTBT_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_tvalid && !out_found, m_tdata[55:5] == '0, "extents set without a found box")

endmodule

bind color_tag_bounding_box_tracker ctbt_checker u_ctbt_checker (.*);
